// ----- sv/gshare_branch_predictor_top_macros.svh -----
// Assertion macros shared by the gshare predictor checker.
// No dependencies; included by files that write concurrent assertions.
`ifndef GSHARE_BRANCH_PREDICTOR_TOP_MACROS_SVH
`define GSHARE_BRANCH_PREDICTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define GSBP_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gsbp assertion failed");

// Next-cycle implication, disabled while rst is high.
`define GSBP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gsbp assertion failed");

`endif

// ----- sv/gsbp_pkg.sv -----
// Shared types and constants for the gshare branch predictor.
// No dependencies; imported by the top level and the checker.
`timescale 1ns / 1ps

package gsbp_pkg;

   localparam int HIST_BITS   = 14;
   localparam int TABLE_DEPTH = 1 << HIST_BITS;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 8;

   // Result queue behind the table read stage.
   localparam int OUT_DEPTH   = 4;
   localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

   typedef logic [HIST_BITS-1:0] idx_type;
   typedef logic [1:0]           ctr_type;
   typedef logic [OUT_PTR_W-1:0] out_ptr_type;
   typedef logic [OUT_CNT_W-1:0] out_cnt_type;

   localparam ctr_type CTR_MAX   = 2'h3;
   localparam ctr_type CTR_MIN   = 2'h0;
   localparam ctr_type CTR_RESET = 2'h1;

   // Item kind carried on tuser.
   localparam logic ACTION_TRAIN = 1'b1;

   // Two-bit saturating counter step.
   function automatic ctr_type ctr_step(ctr_type cur, logic taken);
      ctr_type res;
      res = cur;
      if (taken) begin
         if (cur != CTR_MAX) res = cur + 2'd1;
      end else begin
         if (cur != CTR_MIN) res = cur - 2'd1;
      end
      return res;
   endfunction

endpackage

// ----- sv/gsbp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies; used for the pattern counter table.
`timescale 1ns / 1ps

module gsbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/gshare_branch_predictor_top.sv -----
// Gshare branch predictor top level: history register, counter table, result queue.
// Depends on gsbp_pkg and gsbp_ram.
`timescale 1ns / 1ps

//  channel | direction | tdata fields (low bit up)        | tuser
//  req     | in        | pc[31:0], outcome[32], zero pad  | action (1 = train)
//  rsp     | out       | predicted_taken[0], counter[2:1] | none
//
// An item is read from the table in the cycle it is accepted and its result is
// queued in the next cycle, so one item per cycle is sustained while rsp_tready is high.
// The pattern table is one synchronous RAM; a train item writes its counter back in
// the cycle after acceptance, and a following item that hits the same entry takes the
// new value through a forwarding register.
// After reset a clearing pass writes all 2^HIST_BITS counters to weakly not taken,
// one entry a cycle; req_tready stays low until it is done.
// When the result queue fills because rsp_tready is low, req_tready drops.

module gshare_branch_predictor_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // pc[31:0], outcome[32], zeros[39:33]
   input  logic [gsbp_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action[0]
   input  logic [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // predicted_taken[0], counter_value[2:1], zeros[7:3]
   output logic [gsbp_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import gsbp_pkg::*;

   // Clearing pass state.
   logic    clr_active_ff, clr_active_in;
   idx_type clr_addr_ff, clr_addr_in;

   // Global history.
   idx_type hist_ff, hist_in;

   // Read stage: the item whose counter is arriving from the RAM.
   logic    s1_valid_ff, s1_valid_in;
   logic    s1_train_ff;
   logic    s1_outcome_ff;
   idx_type s1_idx_ff;
   logic    s1_fwd_ff;
   ctr_type s1_fwd_ctr_ff;

   // Result queue.
   ctr_type     out_q_ff [OUT_DEPTH];
   out_ptr_type out_wr_ff, out_wr_in;
   out_ptr_type out_rd_ff, out_rd_in;
   out_cnt_type out_cnt_ff, out_cnt_in;

   logic        accept;
   logic        push;
   logic        pop;
   logic        req_train;
   logic        req_outcome;
   idx_type     req_idx;
   logic [HIST_BITS:0] hist_shift;
   ctr_type     ram_rd_data;
   ctr_type     cur_ctr;
   ctr_type     upd_ctr;
   logic        s1_wr;
   logic        ram_wr_en;
   idx_type     ram_wr_addr;
   ctr_type     ram_wr_data;
   logic [OUT_CNT_W:0] occupancy;

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------
   assign req_train   = (req_tuser[0] == ACTION_TRAIN);
   assign req_outcome = req_tdata[32];
   assign req_idx     = req_tdata[HIST_BITS-1:0] ^ hist_ff;

   // Items already in the read stage are counted, since each of them is pushed into the
   // queue in the next cycle.
   assign occupancy  = {1'b0, out_cnt_ff} + {{OUT_CNT_W{1'b0}}, s1_valid_ff};
   assign req_tready = !clr_active_ff && (occupancy < (OUT_CNT_W+1)'(OUT_DEPTH));
   assign accept     = req_tvalid && req_tready;

   // The outcome of a train item is known at acceptance, so the history moves at
   // once and the next item can index the table in the very next cycle.
   assign hist_shift = {req_outcome, hist_ff};

   always_comb begin
      hist_in = hist_ff;
      if (accept && req_train) hist_in = hist_shift[HIST_BITS:1];
   end

   // ---------------------------------------------------------------------------
   // Clearing pass
   // ---------------------------------------------------------------------------
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) clr_active_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------------
   // Read-modify-write of the counter table
   // ---------------------------------------------------------------------------
   assign s1_valid_in = accept;

   // A train item in the read stage writes its entry at the same edge that the
   // newly accepted item reads; the RAM then returns the old value, so the fresh
   // counter is captured for that item instead.
   assign cur_ctr = s1_fwd_ff ? s1_fwd_ctr_ff : ram_rd_data;
   assign upd_ctr = ctr_step(cur_ctr, s1_outcome_ff);
   assign s1_wr   = s1_valid_ff && s1_train_ff;

   always_comb begin
      if (clr_active_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = CTR_RESET;
      end else begin
         ram_wr_en   = s1_wr;
         ram_wr_addr = s1_idx_ff;
         ram_wr_data = upd_ctr;
      end
   end

   gsbp_ram #(
      .WIDTH ($bits(ctr_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (req_idx),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------------
   // Result queue
   // ---------------------------------------------------------------------------
   assign push = s1_valid_ff;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      out_wr_in  = out_wr_ff;
      out_rd_in  = out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (push) out_wr_in = out_wr_ff + 1'b1;
      if (pop)  out_rd_in = out_rd_ff + 1'b1;
      if (push && !pop)      out_cnt_in = out_cnt_ff + 1'b1;
      else if (pop && !push) out_cnt_in = out_cnt_ff - 1'b1;
   end

   assign rsp_tvalid = (out_cnt_ff != '0);
   assign rsp_tdata  = {{(RSP_TDATA_W-3){1'b0}}, out_q_ff[out_rd_ff], out_q_ff[out_rd_ff][1]};

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         hist_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         out_wr_ff     <= '0;
         out_rd_ff     <= '0;
         out_cnt_ff    <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         hist_ff       <= hist_in;
         s1_valid_ff   <= s1_valid_in;
         out_wr_ff     <= out_wr_in;
         out_rd_ff     <= out_rd_in;
         out_cnt_ff    <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_train_ff   <= req_train;
         s1_outcome_ff <= req_outcome;
         s1_idx_ff     <= req_idx;
         s1_fwd_ff     <= s1_wr && (s1_idx_ff == req_idx);
         s1_fwd_ctr_ff <= upd_ctr;
      end
      if (push) out_q_ff[out_wr_ff] <= cur_ctr;
   end

endmodule

// ----- sv/gsbp_checker.sv -----
// Port-level checker for the gshare branch predictor, bound to the top level.
// Depends on gsbp_pkg and gshare_branch_predictor_top_macros.svh.
`timescale 1ns / 1ps
`include "gshare_branch_predictor_top_macros.svh"

module gsbp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [gsbp_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic [0:0]                       req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [gsbp_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import gsbp_pkg::*;

   logic                 req_waiting;
   logic [REQ_TDATA_W:0] req_item;
   logic                 rsp_fields_ok;

   assign req_waiting   = req_tvalid && !req_tready;
   assign req_item      = {req_tuser, req_tdata};
   assign rsp_fields_ok = (rsp_tdata[0] == rsp_tdata[2]) && (rsp_tdata[RSP_TDATA_W-1:3] == '0);

   // The clearing pass holds off items right after reset.
   `GSBP_ASSERT_IMPLIES(a_clear_after_reset, clock, 1'b0, $past(reset), !req_tready)

   // No result can be pending right after reset.
   `GSBP_ASSERT_IMPLIES(a_no_rsp_after_reset, clock, 1'b0, $past(reset), !rsp_tvalid)

   // The prediction is the high bit of the counter, and the padding is zero.
   `GSBP_ASSERT_IMPLIES(a_pred_matches_ctr, clock, reset, rsp_tvalid, rsp_fields_ok)

   // An offered item that is not taken stays offered and unchanged.
   `GSBP_ASSERT_NEXT(a_req_hold, clock, reset, req_waiting, req_tvalid && $stable(req_item))

   // A result not taken stays offered and unchanged.
   `GSBP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind gshare_branch_predictor_top gsbp_checker u_gsbp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
